// ===== hdl/lcs_pkg.sv =====
// Shared types and codes for the link connect supervisor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lcs_pkg;

  localparam int unsigned TimeW = 32;

  localparam logic [TimeW-1:0] DefaultBackoffMs = 32'd30000;
  localparam logic [TimeW-1:0] DefaultTimeoutMs = 32'd30000;

  localparam int unsigned CfgIndexW = 8;
  localparam logic [CfgIndexW-1:0] RegRetryBackoff  = 8'd0;
  localparam logic [CfgIndexW-1:0] RegConnectTimeout = 8'd1;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    CS_DOWN       = 2'd0,
    CS_CONNECTING = 2'd1,
    CS_UP         = 2'd2
  } conn_state_e;

  typedef enum logic [2:0] {
    LS_DOWN    = 3'd0,
    LS_JOIN    = 3'd1,
    LS_NOIP    = 3'd2,
    LS_UP      = 3'd3,
    LS_FAIL    = 3'd4,
    LS_NONET   = 3'd5,
    LS_BADAUTH = 3'd6
  } link_status_e;

  typedef enum logic [2:0] {
    EV_NONE           = 3'd0,
    EV_INIT_FAILED    = 3'd1,
    EV_CONNECTED      = 3'd2,
    EV_DROPPED        = 3'd3,
    EV_CONNECT_FAILED = 3'd4,
    EV_TIMED_OUT      = 3'd5
  } link_event_e;

  typedef struct packed {
    logic [TimeW-1:0] retry_backoff_ms;
    logic [TimeW-1:0] connect_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic             ready_flag;
    conn_state_e      link_state;
    logic [TimeW-1:0] last_attempt_time;
    logic [TimeW-1:0] connect_start_time;
  } sup_state_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             init_ok;
    logic [2:0]       link_status;
    logic             ssid_present;
    logic             start_ok;
  } in_item_t;

  typedef struct packed {
    logic        radio_ready;
    conn_state_e conn_state;
    link_event_e link_event;
    logic        connect_issued;
    logic        start_failed;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/link_connect_supervisor.sv =====
// Top level of the link connect supervisor: input register, state, result register.
// Depends on lcs_pkg and lcs_step.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata, one poll tick
//   m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata, one result
//   cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each item waits in the input register until it can move on, then the step logic
// updates the state and loads the result register; one item per cycle unless m_axis stalls.
// The state update is a 32-bit subtract and compare, which sets the cycle time.
// Reset clears the state and loads both timing registers with 30000 ms.
// A stalled result holds the result register; the input register still takes a
// new item whenever the item in it can move on in the same cycle.
`default_nettype none

module link_connect_supervisor (
  input  wire                          clk_i,
  input  wire                          rst_ni,

  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] now_ms, [32] init_ok, [35:33] link_status, [36] ssid_present,
  // [37] start_ok, [39:38] zero
  input  wire [lcs_pkg::InDataW-1:0]   s_axis_tdata,

  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [0] radio_ready, [2:1] conn_state, [5:3] link_event, [6] connect_issued,
  // [7] start_failed
  output logic [lcs_pkg::OutDataW-1:0] m_axis_tdata,

  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [lcs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire [lcs_pkg::TimeW-1:0]     cfg_data_i
);
  import lcs_pkg::*;

  cfg_t       cfg_q;
  sup_state_t state_q, state_d;
  in_item_t   in_q, in_d;
  logic       in_valid_q;
  out_item_t  out_q, result;
  logic       out_valid_q;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign in_d.now_ms       = s_axis_tdata[31:0];
  assign in_d.init_ok      = s_axis_tdata[32];
  assign in_d.link_status  = s_axis_tdata[35:33];
  assign in_d.ssid_present = s_axis_tdata[36];
  assign in_d.start_ok     = s_axis_tdata[37];

  lcs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_backoff_ms   <= DefaultBackoffMs;
      cfg_q.connect_timeout_ms <= DefaultTimeoutMs;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRetryBackoff:   cfg_q.retry_backoff_ms   <= cfg_data_i;
        RegConnectTimeout: cfg_q.connect_timeout_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.ready_flag         <= 1'b0;
      state_q.link_state         <= CS_DOWN;
      state_q.last_attempt_time  <= '0;
      state_q.connect_start_time <= '0;
      in_valid_q                 <= 1'b0;
      out_valid_q                <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= in_d;
    if (advance) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.start_failed, out_q.connect_issued, out_q.link_event,
                          out_q.conn_state, out_q.radio_ready};

  // Once the radio has come up it never goes back to not-ready.
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q.ready_flag) |-> state_q.ready_flag)
    else $error("ready flag was cleared");

  // A connect attempt is only ever made by a ready radio.
  a_issue_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.connect_issued) |-> out_q.radio_ready)
    else $error("connect issued while radio not ready");

  // A refused start implies an attempt and leaves the link down.
  a_refused_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.start_failed) |->
      (out_q.connect_issued && out_q.conn_state == CS_DOWN))
    else $error("refused start without attempt or with link not down");

  // A failed init reports nothing else.
  a_init_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.link_event == EV_INIT_FAILED) |->
      (!out_q.radio_ready && !out_q.connect_issued && out_q.conn_state == CS_DOWN))
    else $error("init failure with other activity");

endmodule

`default_nettype wire

// ===== hdl/lcs_step.sv =====
// Per-tick decision logic: next supervisor state and the result of one poll item.
// Purely combinational; uses the types and codes of lcs_pkg.
`default_nettype none

module lcs_step (
  input  lcs_pkg::cfg_t       cfg_i,
  input  lcs_pkg::sup_state_t state_i,
  input  lcs_pkg::in_item_t   item_i,
  output lcs_pkg::sup_state_t state_o,
  output lcs_pkg::out_item_t  result_o
);
  import lcs_pkg::*;

  logic        ready;
  logic        down_logic;
  conn_state_e st;
  link_event_e ev;
  logic        issued;
  logic        refused;
  logic [TimeW-1:0] since_start;
  logic [TimeW-1:0] since_attempt;
  logic        backoff_wait;

  // Differences wrap modulo 2^32 by construction.
  assign since_start   = item_i.now_ms - state_i.connect_start_time;
  assign since_attempt = item_i.now_ms - state_i.last_attempt_time;
  assign backoff_wait  = (state_i.last_attempt_time != '0) &&
                         (since_attempt < cfg_i.retry_backoff_ms);

  always_comb begin
    ready      = state_i.ready_flag;
    down_logic = 1'b1;
    st         = state_i.link_state;
    ev         = EV_NONE;
    issued     = 1'b0;
    refused    = 1'b0;
    state_o    = state_i;

    if (!ready) begin
      if (item_i.init_ok) begin
        ready = 1'b1;
      end else begin
        ev         = EV_INIT_FAILED;
        down_logic = 1'b0;
      end
    end

    if (ready && (st == CS_UP || st == CS_CONNECTING)) begin
      case (item_i.link_status)
        LS_UP: begin
          if (st != CS_UP) ev = EV_CONNECTED;
          st         = CS_UP;
          down_logic = 1'b0;
        end
        LS_JOIN, LS_NOIP: begin
          // The timeout runs only for an attempt that is still connecting.
          if (st == CS_CONNECTING && since_start > cfg_i.connect_timeout_ms) begin
            ev = EV_TIMED_OUT;
            st = CS_DOWN;
          end else begin
            st         = CS_CONNECTING;
            down_logic = 1'b0;
          end
        end
        default: begin
          ev = (st == CS_UP) ? EV_DROPPED : EV_CONNECT_FAILED;
          st = CS_DOWN;
        end
      endcase
    end

    // A drop and a fresh attempt may both happen in the same tick.
    if (ready && down_logic && st != CS_UP && st != CS_CONNECTING) begin
      st = CS_DOWN;
      if (item_i.ssid_present && !backoff_wait) begin
        state_o.last_attempt_time = item_i.now_ms;
        issued = 1'b1;
        if (item_i.start_ok) begin
          st = CS_CONNECTING;
          state_o.connect_start_time = item_i.now_ms;
        end else begin
          refused = 1'b1;
        end
      end
    end

    state_o.ready_flag = ready;
    state_o.link_state = st;

    result_o.radio_ready    = ready;
    result_o.conn_state     = st;
    result_o.link_event     = ev;
    result_o.connect_issued = issued;
    result_o.start_failed   = refused;
  end

endmodule

`default_nettype wire

// ===== sim/tb_link_connect_supervisor.sv =====
// Self-checking testbench for link_connect_supervisor: random stream traffic with
// back-pressure, register writes between phases, results checked against a predictor.
// Depends on lcs_pkg and the RTL of the block.

module tb_link_connect_supervisor;
  import lcs_pkg::*;

  // Scoreboard: mirrors the supervisor state and keeps the results still owed by the block.
  class link_scoreboard;
    logic [TimeW-1:0] backoff_ms;
    logic [TimeW-1:0] timeout_ms;
    logic             ready;
    conn_state_e      link_st;
    logic [TimeW-1:0] last_try_ms;
    logic [TimeW-1:0] join_start_ms;
    out_item_t        owed_q[$];
    int unsigned      n_errors;
    int unsigned      n_checked;
    int unsigned      n_issued;
    int unsigned      n_refused;
    int unsigned      ev_count[8];

    function new();
      backoff_ms    = DefaultBackoffMs;
      timeout_ms    = DefaultTimeoutMs;
      ready         = 1'b0;
      link_st       = CS_DOWN;
      last_try_ms   = '0;
      join_start_ms = '0;
      n_errors      = 0;
      n_checked     = 0;
      n_issued      = 0;
      n_refused     = 0;
      foreach (ev_count[i]) ev_count[i] = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [TimeW-1:0] val);
      if (idx == RegRetryBackoff) begin
        backoff_ms = val;
      end else if (idx == RegConnectTimeout) begin
        timeout_ms = val;
      end
    endfunction

    // Advances the supervisor by one poll tick and returns the result it reports.
    function out_item_t poll(in_item_t t);
      out_item_t        r;
      logic             may_retry;
      logic [TimeW-1:0] elapsed;
      logic [TimeW-1:0] since;
      r.link_event     = EV_NONE;
      r.connect_issued = 1'b0;
      r.start_failed   = 1'b0;
      may_retry        = 1'b1;
      if (!ready) begin
        if (t.init_ok) begin
          ready = 1'b1;
        end else begin
          r.link_event = EV_INIT_FAILED;
          may_retry    = 1'b0;
        end
      end
      if (ready && (link_st == CS_UP || link_st == CS_CONNECTING)) begin
        if (t.link_status == LS_UP) begin
          if (link_st != CS_UP) r.link_event = EV_CONNECTED;
          link_st   = CS_UP;
          may_retry = 1'b0;
        end else if (t.link_status == LS_JOIN || t.link_status == LS_NOIP) begin
          // A join seen while up falls back without restarting the join timer.
          elapsed = t.now_ms - join_start_ms;
          if (link_st == CS_CONNECTING && elapsed > timeout_ms) begin
            r.link_event = EV_TIMED_OUT;
            link_st      = CS_DOWN;
          end else begin
            link_st   = CS_CONNECTING;
            may_retry = 1'b0;
          end
        end else begin
          if (link_st == CS_UP) r.link_event = EV_DROPPED;
          else r.link_event = EV_CONNECT_FAILED;
          link_st = CS_DOWN;
        end
      end
      if (ready && may_retry && link_st == CS_DOWN) begin
        // A stored attempt time of zero means no attempt has been made yet.
        since = t.now_ms - last_try_ms;
        if (t.ssid_present && !(last_try_ms != '0 && since < backoff_ms)) begin
          last_try_ms      = t.now_ms;
          r.connect_issued = 1'b1;
          if (t.start_ok) begin
            link_st       = CS_CONNECTING;
            join_start_ms = t.now_ms;
          end else begin
            r.start_failed = 1'b1;
          end
        end
      end
      r.radio_ready = ready;
      r.conn_state  = link_st;
      return r;
    endfunction

    function void note_tick(logic [InDataW-1:0] d);
      in_item_t t;
      t.now_ms       = d[31:0];
      t.init_ok      = d[32];
      t.link_status  = d[35:33];
      t.ssid_present = d[36];
      t.start_ok     = d[37];
      owed_q.push_back(poll(t));
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      out_item_t exp;
      if (owed_q.size() == 0) begin
        $error("result %h arrived with no tick outstanding", d);
        n_errors++;
        return;
      end
      exp = owed_q.pop_front();
      n_checked++;
      ev_count[exp.link_event]++;
      if (exp.connect_issued) n_issued++;
      if (exp.start_failed) n_refused++;
      if (d[0] !== exp.radio_ready) begin
        $error("radio_ready: expected %0b, got %0b", exp.radio_ready, d[0]);
        n_errors++;
      end
      if (d[2:1] !== exp.conn_state) begin
        $error("conn_state: expected %0d, got %0d", exp.conn_state, d[2:1]);
        n_errors++;
      end
      if (d[5:3] !== exp.link_event) begin
        $error("link_event: expected %0d, got %0d", exp.link_event, d[5:3]);
        n_errors++;
      end
      if (d[6] !== exp.connect_issued) begin
        $error("connect_issued: expected %0b, got %0b", exp.connect_issued, d[6]);
        n_errors++;
      end
      if (d[7] !== exp.start_failed) begin
        $error("start_failed: expected %0b, got %0b", exp.start_failed, d[7]);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [TimeW-1:0]     cfg_data_i = '0;

  logic                 rx_steady = 1'b0;
  int unsigned          rx_hold = 0;
  int unsigned          n_settings = 1;
  link_scoreboard       sb;

  link_connect_supervisor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= idle_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  function automatic in_item_t make_tick(logic [TimeW-1:0] now, logic init_ok,
                                         logic [2:0] status, logic ssid, logic start_ok);
    in_item_t t;
    t.now_ms       = now;
    t.init_ok      = init_ok;
    t.link_status  = status;
    t.ssid_present = ssid;
    t.start_ok     = start_ok;
    return t;
  endfunction

  // Leaves valid high on return, so back-to-back items need no extra edge.
  task automatic send_tick(in_item_t t);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t.start_ok, t.ssid_present, t.link_status, t.init_ok, t.now_ms};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic hold_off(int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every tick has its result, then lets the two-stage pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [TimeW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Only called with the block idle. A write to an unmapped index rides along.
  task automatic configure(logic [TimeW-1:0] backoff, logic [TimeW-1:0] timeout);
    logic [CfgIndexW-1:0] stray_idx;
    stray_idx = RegConnectTimeout + CfgIndexW'($urandom_range(1, 254));
    write_reg(RegRetryBackoff, backoff);
    write_reg(RegConnectTimeout, timeout);
    write_reg(stray_idx, $urandom);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic send_paced(in_item_t t);
    send_tick(t);
    if ($urandom_range(0, 2) == 0) hold_off(idle_len());
  endtask

  // Walks the state machine through each transition under the reset-time settings.
  task automatic run_directed();
    send_paced(make_tick(32'd100, 1'b0, LS_UP, 1'b1, 1'b1));
    send_paced(make_tick(32'd0, 1'b1, LS_DOWN, 1'b1, 1'b1));
    send_paced(make_tick(32'd10, 1'b0, LS_JOIN, 1'b1, 1'b1));
    send_paced(make_tick(32'd30000, 1'b1, LS_NOIP, 1'b1, 1'b1));
    send_paced(make_tick(32'd30001, 1'b1, LS_JOIN, 1'b1, 1'b1));
    send_paced(make_tick(32'd30002, 1'b1, LS_UP, 1'b1, 1'b1));
    send_paced(make_tick(32'd90000, 1'b1, LS_JOIN, 1'b1, 1'b1));
    send_paced(make_tick(32'd90001, 1'b1, LS_NOIP, 1'b1, 1'b0));
    send_paced(make_tick(32'd90002, 1'b1, LS_DOWN, 1'b1, 1'b1));
    send_paced(make_tick(32'd120001, 1'b1, LS_DOWN, 1'b0, 1'b1));
    send_paced(make_tick(32'd120001, 1'b1, LS_DOWN, 1'b1, 1'b1));
    // Status code 7 is not assigned and must count as a failure.
    send_paced(make_tick(32'd120005, 1'b1, 3'd7, 1'b1, 1'b1));
    send_paced(make_tick(32'd150005, 1'b1, LS_FAIL, 1'b1, 1'b1));
    send_paced(make_tick(32'd150006, 1'b1, LS_UP, 1'b1, 1'b1));
    send_paced(make_tick(32'd150007, 1'b1, LS_NONET, 1'b1, 1'b1));
    send_paced(make_tick(32'd180007, 1'b1, LS_BADAUTH, 1'b1, 1'b1));
    send_paced(make_tick(32'd180008, 1'b1, LS_BADAUTH, 1'b1, 1'b1));
    send_paced(make_tick(32'hFFFF_FF00, 1'b1, LS_DOWN, 1'b1, 1'b1));
    send_paced(make_tick(32'h0000_0100, 1'b1, LS_JOIN, 1'b1, 1'b1));
    send_paced(make_tick(32'hFFFF_FFFF, 1'b1, LS_UP, 1'b1, 1'b1));
    send_paced(make_tick(32'd0, 1'b1, LS_DOWN, 1'b1, 1'b1));
    send_paced(make_tick(32'd40000, 1'b1, LS_DOWN, 1'b1, 1'b1));
    drain();
  endtask

  // Most ticks follow a running clock with plausible status; a few are pure noise.
  task automatic run_phase(int unsigned n_ticks, int unsigned step_max, bit steady);
    logic [TimeW-1:0] clock_ms;
    logic [2:0]       status;
    int unsigned      pick;
    in_item_t         t;
    rx_steady <= steady;
    if ($urandom_range(0, 1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else clock_ms = $urandom;
    for (int unsigned i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        t = make_tick($urandom, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        clock_ms += $urandom_range(0, step_max);
        pick = $urandom_range(0, 9);
        if (pick < 3) status = 3'($urandom_range(LS_JOIN, LS_NOIP));
        else if (pick < 6) status = LS_UP;
        else if (pick < 8) status = 3'($urandom_range(LS_FAIL, 7));
        else status = LS_DOWN;
        t = make_tick(clock_ms, $urandom_range(0, 3) != 0, status,
                      $urandom_range(0, 7) != 0, $urandom_range(0, 4) != 0);
      end
      send_tick(t);
      if ($urandom_range(0, 59) == 0) drain();
      else if (!steady && $urandom_range(0, 2) == 0) hold_off(idle_len());
    end
    drain();
    rx_steady <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    configure(32'd0, 32'd0);
    run_phase(125, 20, 1'b0);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(125, 50, 1'b0);
    configure(32'd0, 32'hFFFF_FFFF);
    run_phase(125, 50, 1'b0);
    configure(32'hFFFF_FFFF, 32'd0);
    run_phase(125, 50, 1'b0);
    configure($urandom_range(0, 100), $urandom_range(0, 100));
    run_phase(125, 60, 1'b1);
    configure($urandom_range(0, 100), $urandom_range(0, 100));
    run_phase(125, 60, 1'b0);
    configure($urandom_range(0, 100), $urandom_range(0, 100));
    run_phase(125, 60, 1'b0);
    configure($urandom_range(1000, 60000), $urandom_range(1000, 60000));
    run_phase(125, 25000, 1'b0);
    $display("Checked %0d results under %0d timing settings: %0d connects issued, %0d refused.",
             sb.n_checked, n_settings, sb.n_issued, sb.n_refused);
    $display("Events: %0d init failed, %0d connected, %0d dropped, %0d failed, %0d timed out.",
             sb.ev_count[EV_INIT_FAILED], sb.ev_count[EV_CONNECTED], sb.ev_count[EV_DROPPED],
             sb.ev_count[EV_CONNECT_FAILED], sb.ev_count[EV_TIMED_OUT]);
    if (sb.n_errors == 0) begin
      $display("tb_link_connect_supervisor: done, clean");
    end else begin
      $display("tb_link_connect_supervisor: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $error("simulation stalled: %0d results still outstanding", sb.pending());
    $display("tb_link_connect_supervisor: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lcs_pkg.sv
hdl/lcs_step.sv
hdl/link_connect_supervisor.sv
sim/tb_link_connect_supervisor.sv
